// ===== rtl/swa_pkg.sv =====
// Shared types, widths and constants for the sliding window average unit.
package swa_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 38;
    localparam int LEN_W      = 7;
    localparam int MAX_WINDOW = 64;
    localparam int SLOT_W     = 6;
    localparam int SCALE      = 10000;
    localparam int SCALE_W    = 14;
    localparam int PROD_W     = 52;
    localparam int MAG_W      = 51;
    localparam int AVG_W      = 46;
    localparam int REM_W      = 6;
    localparam int STEP_W     = 6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } swa_in_t;

    typedef struct packed {
        logic signed [AVG_W-1:0] average_scaled;
        logic                    last_average;
    } swa_out_t;

    typedef struct packed {
        logic done;
        logic rem_nonzero;
    } swa_div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_SCALE,
        ST_NORM,
        ST_DIVIDE,
        ST_OUT
    } swa_state_t;

endpackage

// ===== rtl/sliding_window_average_unit.sv =====
// Top level: ring store, running sum, sequencer and scaled floor average output.
// An item that completes a window is scaled, normalised and passed through the 51-step
// serial divider before its result is offered; s_ready is high only in idle, so no new
// item is taken until the last one is through.
// Reset (aresetn low, synchronous): window length 1, sum, fill count and ring
// position cleared, no result pending; the ring store itself is not cleared.
module sliding_window_average_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  swa_pkg::swa_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output swa_pkg::swa_out_t           m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [swa_pkg::LEN_W-1:0]   cfg_window_len
);

    swa_pkg::swa_state_t state_reg, state_next;

    logic [swa_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [swa_pkg::LEN_W-1:0]         fill_reg, fill_next;
    logic [swa_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic signed [swa_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic signed [swa_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                              last_reg, last_next;
    logic signed [swa_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                              neg_reg, neg_next;
    logic signed [swa_pkg::AVG_W-1:0]  avg_reg, avg_next;
    logic                              m_valid_reg, m_valid_next;
    swa_pkg::swa_out_t                 m_data_reg, m_data_next;

    logic [swa_pkg::SLOT_W-1:0]        slot_use;
    logic [swa_pkg::LEN_W-1:0]         slot_inc;
    logic                              full;
    logic [swa_pkg::SAMPLE_W-1:0]      rd_data;
    logic                              ram_we;
    logic                              div_start;
    logic [swa_pkg::PROD_W-1:0]        mag_full;
    logic [swa_pkg::MAG_W-1:0]         quotient;
    swa_pkg::swa_div_stat_t            div_stat;
    logic [swa_pkg::AVG_W-1:0]         q_low;
    logic [swa_pkg::LEN_W-1:0]         cfg_eff;
    logic signed [swa_pkg::SCALE_W:0]  scale_k;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == swa_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign scale_k   = (swa_pkg::SCALE_W + 1)'(swa_pkg::SCALE);

    always_comb begin
        if (cfg_window_len == '0) begin
            cfg_eff = swa_pkg::LEN_W'(1);
        end else if (cfg_window_len > swa_pkg::LEN_W'(swa_pkg::MAX_WINDOW)) begin
            cfg_eff = swa_pkg::LEN_W'(swa_pkg::MAX_WINDOW);
        end else begin
            cfg_eff = cfg_window_len;
        end
    end

    assign slot_use = ({1'b0, slot_reg} >= len_reg) ? '0 : slot_reg;
    assign slot_inc = {1'b0, slot_reg} + 1'b1;
    assign full     = (fill_reg >= len_reg);
    assign ram_we   = (state_reg == swa_pkg::ST_ACCUM);
    assign mag_full = prod_reg[swa_pkg::PROD_W-1] ? -prod_reg : prod_reg;
    assign q_low    = quotient[swa_pkg::AVG_W-1:0];

    swa_ram #(
        .WIDTH(swa_pkg::SAMPLE_W),
        .DEPTH(swa_pkg::MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (s_valid && s_ready),
        .rd_addr (slot_use),
        .rd_data (rd_data)
    );

    swa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_full[swa_pkg::MAG_W-1:0]),
        .divisor  (len_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        fill_next    = fill_reg;
        slot_next    = slot_reg;
        sum_next     = sum_reg;
        sample_next  = sample_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        avg_next     = avg_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            swa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_data.sample;
                    last_next   = s_data.last_sample;
                    slot_next   = slot_use;
                    state_next  = swa_pkg::ST_ACCUM;
                end
            end
            swa_pkg::ST_ACCUM: begin
                sum_next = sum_reg
                         - (full ? {{(swa_pkg::SUM_W-swa_pkg::SAMPLE_W){rd_data[swa_pkg::SAMPLE_W-1]}},
                                    rd_data}
                                 : '0)
                         + {{(swa_pkg::SUM_W-swa_pkg::SAMPLE_W){sample_reg[swa_pkg::SAMPLE_W-1]}},
                            sample_reg};
                fill_next = full ? len_reg : fill_reg + 1'b1;
                slot_next = (slot_inc >= len_reg) ? '0 : slot_inc[swa_pkg::SLOT_W-1:0];
                if (fill_next == len_reg) begin
                    state_next = swa_pkg::ST_SCALE;
                end else begin
                    state_next = swa_pkg::ST_IDLE;
                    if (last_reg) begin
                        sum_next  = '0;
                        fill_next = '0;
                        slot_next = '0;
                    end
                end
            end
            swa_pkg::ST_SCALE: begin
                prod_next  = sum_reg * scale_k;
                state_next = swa_pkg::ST_NORM;
                if (last_reg) begin
                    sum_next  = '0;
                    fill_next = '0;
                    slot_next = '0;
                end
            end
            swa_pkg::ST_NORM: begin
                neg_next   = prod_reg[swa_pkg::PROD_W-1];
                state_next = swa_pkg::ST_DIVIDE;
            end
            swa_pkg::ST_DIVIDE: begin
                if (div_stat.done) begin
                    avg_next   = neg_reg ? -(q_low + swa_pkg::AVG_W'(div_stat.rem_nonzero))
                                         : q_low;
                    state_next = swa_pkg::ST_OUT;
                end
            end
            swa_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.average_scaled = avg_reg;
                    m_data_next.last_average   = last_reg;
                    state_next                 = swa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swa_pkg::ST_IDLE;
            end
        endcase

        if (state_reg == swa_pkg::ST_NORM) begin
            div_start = 1'b1;
        end

        if (cfg_valid) begin
            len_next  = cfg_eff;
            sum_next  = '0;
            fill_next = '0;
            slot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swa_pkg::ST_IDLE;
            len_reg     <= swa_pkg::LEN_W'(1);
            fill_reg    <= '0;
            slot_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            fill_reg    <= fill_next;
            slot_reg    <= slot_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg <= sample_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        avg_reg    <= avg_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== rtl/swa_ram.sv =====
// Generic single-port-write, registered-read RAM.
module swa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/swa_div.sv =====
// Serial restoring divider: one quotient bit per cycle, magnitude by window length.
module swa_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [swa_pkg::MAG_W-1:0]        dividend,
    input  logic [swa_pkg::LEN_W-1:0]        divisor,
    output logic [swa_pkg::MAG_W-1:0]        quotient,
    output swa_pkg::swa_div_stat_t           stat
);

    logic [swa_pkg::MAG_W-1:0]  quo_reg, quo_next;
    logic [swa_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [swa_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [swa_pkg::LEN_W-1:0]  trial;
    logic [swa_pkg::LEN_W-1:0]  diff;
    logic                       ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[swa_pkg::MAG_W-1]};
        ge        = (trial >= divisor);
        diff      = trial - divisor;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[swa_pkg::MAG_W-2:0], ge};
            rem_next  = ge ? diff[swa_pkg::REM_W-1:0] : trial[swa_pkg::REM_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == swa_pkg::STEP_W'(swa_pkg::MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient         = quo_reg;
    assign stat.done        = done_reg;
    assign stat.rem_nonzero = (rem_reg != '0);

endmodule

// ===== tb/sv/tb_sliding_window_average_unit.sv =====
// Self-checking testbench for the sliding window average unit.
module tb_sliding_window_average_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS   = 1550;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_CYC   = 80;
    localparam int TAIL_CYC     = 100;
    localparam int N_DIR        = 21;
    localparam int N_FORCED     = 5;

    typedef struct {
        bit                                  cfg_en;
        logic [swa_pkg::LEN_W-1:0]           cfg_val;
        logic signed [swa_pkg::SAMPLE_W-1:0] smp;
        bit                                  last;
        bit                                  typed;
        logic signed [swa_pkg::AVG_W-1:0]    t_avg;
        bit                                  t_last;
    } dir_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    swa_pkg::swa_in_t          s_data = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    swa_pkg::swa_out_t         m_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [swa_pkg::LEN_W-1:0] cfg_window_len = '0;

    longint                    ring_val [swa_pkg::MAX_WINDOW];
    longint                    win_sum;
    int                        win_fill;
    int                        win_slot;
    logic [swa_pkg::LEN_W-1:0] win_len_reg;

    swa_pkg::swa_out_t         avg_queue [$];
    swa_pkg::swa_out_t         want_avg;
    int                        err_count = 0;
    int                        idle_cycles = 0;
    bit                        sender_gaps = 1'b0;
    bit                        sink_stalls = 1'b0;
    int                        hold_left = 0;

    dir_row_t dir_rows [N_DIR] = '{
        '{1'b0, 7'd0,   32'sh7FFFFFFF, 1'b0, 1'b1, 46'sd21474836470000, 1'b0},
        '{1'b0, 7'd0,   32'sh80000000, 1'b0, 1'b1, -46'sd21474836480000, 1'b0},
        '{1'b0, 7'd0,   -32'sd1,       1'b1, 1'b1, -46'sd10000, 1'b1},
        '{1'b0, 7'd0,   32'sd0,        1'b0, 1'b1, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sd1,        1'b1, 1'b1, 46'sd10000, 1'b1},
        '{1'b1, 7'd3,   32'sd1,        1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sd1,        1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sd2,        1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   -32'sd7,       1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b1, 7'd4,   32'sd5,        1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sd6,        1'b1, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sd7,        1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sd8,        1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sd9,        1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sd10,       1'b1, 1'b0, 46'sd0, 1'b0},
        '{1'b1, 7'd0,   32'sd3,        1'b1, 1'b1, 46'sd30000, 1'b1},
        '{1'b1, 7'd127, 32'sh80000000, 1'b1, 1'b0, 46'sd0, 1'b0},
        '{1'b1, 7'd2,   32'sh7FFFFFFF, 1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sh7FFFFFFF, 1'b0, 1'b0, 46'sd0, 1'b0},
        '{1'b0, 7'd0,   32'sh80000000, 1'b1, 1'b0, 46'sd0, 1'b0},
        '{1'b1, 7'd1,   32'sh80000000, 1'b1, 1'b1, -46'sd21474836480000, 1'b1}
    };

    logic [swa_pkg::LEN_W-1:0] forced_len [N_FORCED] = '{7'd64, 7'd127, 7'd0, 7'd65, 7'd1};

    sliding_window_average_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_window_len (cfg_window_len)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int window_size(input logic [swa_pkg::LEN_W-1:0] len);
        if (len == '0) return 1;
        if (len > swa_pkg::MAX_WINDOW) return swa_pkg::MAX_WINDOW;
        return int'(len);
    endfunction

    function automatic void clear_window();
        win_sum  = 0;
        win_fill = 0;
        win_slot = 0;
    endfunction

    function automatic bit advance_window(input swa_pkg::swa_in_t item,
                                          output swa_pkg::swa_out_t avg);
        int     len;
        longint smp;
        longint num;
        longint quo;
        bit     got;
        len = window_size(win_len_reg);
        smp = longint'($signed(item.sample));
        got = 1'b0;
        avg = '0;
        if (win_slot >= len) win_slot = 0;
        if (win_fill >= len) begin
            win_sum  -= ring_val[win_slot];
            win_fill = len;
        end else begin
            win_fill++;
        end
        ring_val[win_slot] = smp;
        win_sum += smp;
        win_slot = (win_slot + 1 >= len) ? 0 : win_slot + 1;
        if (win_fill == len) begin
            num = win_sum * longint'(swa_pkg::SCALE);
            quo = num / longint'(len);
            if ((num % longint'(len)) != 0 && num < 0) quo -= 1;
            avg.average_scaled = quo[swa_pkg::AVG_W-1:0];
            avg.last_average   = item.last_sample;
            got = 1'b1;
        end
        if (item.last_sample) clear_window();
        return got;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [swa_pkg::SAMPLE_W-1:0] pick_sample(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 1) return 32'sh7FFFFFFF;
        if (mode == 2) return 32'sh80000000;
        if (r < 10) return 32'sh7FFFFFFF;
        if (r < 20) return 32'sh80000000;
        if (r < 23) return 32'sd0;
        if (r < 26) return -32'sd1;
        if (r < 50) return $signed($urandom_range(0, 2000)) - 32'sd1000;
        return $signed($urandom());
    endfunction

    task automatic send_sample(input swa_pkg::swa_in_t item, input bit typed,
                               input swa_pkg::swa_out_t t_avg);
        int                gap;
        bit                took;
        bit                got;
        swa_pkg::swa_out_t pred;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        got = advance_window(item, pred);
        if (typed) avg_queue.push_back(t_avg);
        else if (got) avg_queue.push_back(pred);
    endtask

    // hold the sender until every pending average is out, then let the block go idle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (avg_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_window(input logic [swa_pkg::LEN_W-1:0] len);
        bit took;
        cfg_valid      <= 1'b1;
        cfg_window_len <= len;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        cfg_valid <= 1'b0;
        win_len_reg = len;
        clear_window();
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!sink_stalls) begin
            m_ready <= 1'b1;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if ($urandom_range(0, 99) < 65) begin
            m_ready <= 1'b1;
        end else begin
            m_ready   <= 1'b0;
            hold_left <= ($urandom_range(0, 99) < 95) ? $urandom_range(0, 3)
                                                      : $urandom_range(20, 60);
        end
    end

    // values at the falling edge are the ones the next rising edge accepts
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (avg_queue.size() == 0) begin
                err_count++;
                $display("%0t: unexpected average expected none actual %0d last %0b",
                         $realtime, m_data.average_scaled, m_data.last_average);
            end else begin
                want_avg = avg_queue.pop_front();
                if (m_data.average_scaled !== want_avg.average_scaled) begin
                    err_count++;
                    $display("%0t: average_scaled expected %0d actual %0d", $realtime,
                             want_avg.average_scaled, m_data.average_scaled);
                end
                if (m_data.last_average !== want_avg.last_average) begin
                    err_count++;
                    $display("%0t: last_average expected %0b actual %0b", $realtime,
                             want_avg.last_average, m_data.last_average);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        swa_pkg::swa_in_t          item;
        swa_pkg::swa_out_t         t_avg;
        logic [swa_pkg::LEN_W-1:0] wl;
        int                        rand_items;
        int                        phase_idx;
        int                        eff;
        int                        n_sets;
        int                        set_len;
        int                        set_mode;
        int                        r;
        bit                        close_last;

        foreach (ring_val[i]) ring_val[i] = 0;
        win_len_reg = 7'd1;
        clear_window();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_en) begin
                drain_results();
                write_window(dir_rows[i].cfg_val);
            end
            item.sample            = dir_rows[i].smp;
            item.last_sample       = dir_rows[i].last;
            t_avg.average_scaled   = dir_rows[i].t_avg;
            t_avg.last_average     = dir_rows[i].t_last;
            send_sample(item, dir_rows[i].typed, t_avg);
        end

        rand_items = 0;
        phase_idx  = 0;
        while (rand_items < RAND_ITEMS) begin
            if (phase_idx < N_FORCED) begin
                wl = forced_len[phase_idx];
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) wl = swa_pkg::LEN_W'($urandom_range(1, 8));
                else if (r < 90) wl = swa_pkg::LEN_W'($urandom_range(9, 64));
                else if (r < 95) wl = '0;
                else wl = swa_pkg::LEN_W'($urandom_range(65, 127));
            end
            phase_idx++;
            drain_results();
            write_window(wl);
            sender_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            eff        = window_size(wl);
            n_sets     = (eff > 16) ? 1 : $urandom_range(1, 4);
            close_last = ($urandom_range(0, 4) != 0);
            for (int k = 0; k < n_sets; k++) begin
                if ($urandom_range(0, 99) < 85) set_len = eff + $urandom_range(0, 2 * eff + 12);
                else set_len = $urandom_range(1, eff);
                r = $urandom_range(0, 99);
                set_mode = (r < 5) ? 1 : (r < 10) ? 2 : 0;
                for (int j = 0; j < set_len; j++) begin
                    item.sample      = pick_sample(set_mode);
                    item.last_sample = (j == set_len - 1) && (close_last || k < n_sets - 1);
                    if ($urandom_range(0, 19) == 0) item.last_sample = 1'b1;
                    send_sample(item, 1'b0, '0);
                    rand_items++;
                    if (rand_items == 400 || $urandom_range(0, 299) == 0) drain_results();
                end
            end
        end

        s_valid <= 1'b0;
        while (avg_queue.size() != 0) @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/swa_pkg.sv
rtl/swa_ram.sv
rtl/swa_div.sv
rtl/sliding_window_average_unit.sv
tb/sv/tb_sliding_window_average_unit.sv
